// File: hw/rtl/fbtc_pkg.sv
// Shared types and constants for the framebuffer text console.
package fbtc_pkg;

  localparam int GLYPH_COUNT_DEF = 128;
  localparam int GLYPH_ROWS      = 8;

  localparam int POS_W   = 14;
  localparam int ADDR_W  = 26;
  localparam int COLOR_W = 32;
  localparam int CODE_W  = 8;
  localparam int ROW_W   = 3;

  localparam logic [POS_W-1:0] CELL_W = 14'd8;
  localparam logic [POS_W-1:0] LINE_H = 14'd10;

  localparam logic [COLOR_W-1:0] TEXT_COLOR  = 32'hFFFF_FFFF;
  localparam logic [COLOR_W-1:0] BLANK_COLOR = 32'h0000_0000;

  localparam logic [CODE_W-1:0] CODE_LIMIT = 8'd128;
  localparam logic [CODE_W-1:0] CHAR_NUL   = 8'd0;
  localparam logic [CODE_W-1:0] CHAR_BS    = 8'd8;
  localparam logic [CODE_W-1:0] CHAR_LF    = 8'd10;
  localparam logic [CODE_W-1:0] CHAR_SPACE = 8'd32;

  localparam logic [POS_W-1:0] WIDTH_RST  = 14'd640;
  localparam logic [POS_W-1:0] HEIGHT_RST = 14'd480;
  localparam logic [POS_W-1:0] PITCH_RST  = 14'd640;

  typedef enum logic [1:0] {
    REG_WIDTH,
    REG_HEIGHT,
    REG_PITCH,
    REG_FB_PRESENT
  } reg_idx_t;

  typedef enum logic [2:0] {
    CUR_HOLD,
    CUR_BACK,
    CUR_NEWLINE,
    CUR_ADVANCE,
    CUR_WRAP
  } cur_op_t;

  typedef enum logic [2:0] {
    KIND_FONT,
    KIND_NULL,
    KIND_NEWLINE,
    KIND_BACK,
    KIND_PRINT
  } item_kind_t;

  typedef struct packed {
    logic    font_write;
    logic    latch;
    logic    row_start;
    logic    row_read;
    logic    scan;
    logic    flush;
    cur_op_t cur_op;
  } dp_cmd_t;

  typedef struct packed {
    item_kind_t kind;
    logic       draw_en;
    logic       bit_last;
    logic       row_last;
    logic       scan_stall;
    logic       flush_stall;
  } dp_sts_t;

endpackage

// File: hw/rtl/fbtc_ctrl.sv
// Sequencer for the text console: decodes requests and steps the glyph scan.
module fbtc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  fbtc_pkg::dp_sts_t sts,
  output fbtc_pkg::dp_cmd_t cmd
);
  import fbtc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_FLUSH,
    ST_FINISH
  } state_t;

  state_t state;
  state_t state_next;
  logic   back;
  logic   back_next;
  logic   accept;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    cmd        = '0;
    cmd.cur_op = CUR_HOLD;
    state_next = state;
    back_next  = back;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (sts.kind)
            KIND_FONT: cmd.font_write = 1'b1;
            KIND_NULL: ;
            KIND_NEWLINE: cmd.cur_op = CUR_NEWLINE;
            KIND_BACK: begin
              // step the cursor back first, then blank the cell there
              cmd.cur_op    = CUR_BACK;
              cmd.latch     = 1'b1;
              cmd.row_start = 1'b1;
              back_next     = 1'b1;
              state_next    = sts.draw_en ? ST_READ : ST_FINISH;
            end
            KIND_PRINT: begin
              cmd.latch     = 1'b1;
              cmd.row_start = 1'b1;
              back_next     = 1'b0;
              state_next    = sts.draw_en ? ST_READ : ST_FINISH;
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        cmd.row_read = 1'b1;
        state_next   = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (!sts.scan_stall && sts.bit_last) begin
          state_next = sts.row_last ? ST_FLUSH : ST_READ;
        end
      end
      ST_FLUSH: begin
        cmd.flush = 1'b1;
        if (!sts.flush_stall) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        cmd.cur_op = back ? CUR_WRAP : CUR_ADVANCE;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      back  <= 1'b0;
    end else begin
      state <= state_next;
      back  <= back_next;
    end
  end

endmodule

// File: hw/rtl/fbtc_dp.sv
// Datapath: cursor, glyph store, pixel address generation and output register.
module fbtc_dp #(
  parameter int GLYPH_COUNT = fbtc_pkg::GLYPH_COUNT_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  fbtc_pkg::dp_cmd_t         cmd,
  output fbtc_pkg::dp_sts_t         sts,
  input  logic [fbtc_pkg::POS_W-1:0] screen_width,
  input  logic [fbtc_pkg::POS_W-1:0] screen_height,
  input  logic [fbtc_pkg::POS_W-1:0] line_pitch,
  input  logic                      framebuffer_present,
  input  logic [23:0]               s_tdata,
  input  logic                      s_tuser,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [63:0]               m_tdata,
  output logic                      m_tlast
);
  import fbtc_pkg::*;

  localparam int MEM_DEPTH = GLYPH_COUNT * GLYPH_ROWS;
  localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam logic [CODE_W:0] GLYPH_LIMIT = (CODE_W + 1)'(GLYPH_COUNT);

  // input fields
  logic [CODE_W-1:0] in_code;
  logic [ROW_W-1:0]  in_row;
  logic [7:0]        in_bits;
  logic [CODE_W-1:0] in_glyph;
  logic              in_stored;

  assign in_code   = s_tdata[7:0];
  assign in_row    = s_tdata[10:8];
  assign in_bits   = s_tdata[18:11];
  assign in_glyph  = (in_code == CHAR_BS) ? CHAR_SPACE : in_code;
  assign in_stored = ({1'b0, in_code} < GLYPH_LIMIT);

  assign sts.kind = s_tuser                 ? KIND_FONT    :
                    (in_code == CHAR_NUL)   ? KIND_NULL    :
                    (in_code == CHAR_LF)    ? KIND_NEWLINE :
                    (in_code == CHAR_BS)    ? KIND_BACK    : KIND_PRINT;

  assign sts.draw_en = framebuffer_present && (in_glyph < CODE_LIMIT) &&
                       ({1'b0, in_glyph} < GLYPH_LIMIT);

  // glyph store
  logic [7:0]        glyph_mem [MEM_DEPTH];
  logic [10:0]       waddr_full;
  logic [10:0]       raddr_full;
  logic [CODE_W-1:0] glyph;
  logic [7:0]        rdata;
  logic [ROW_W-1:0]  row;
  logic [ROW_W-1:0]  bitc;

  assign waddr_full = {in_code, in_row};
  assign raddr_full = {glyph, row};

  always_ff @(posedge clk) begin
    if (cmd.font_write && in_stored) begin
      glyph_mem[waddr_full[MEM_AW-1:0]] <= in_bits;
    end
    if (cmd.row_read) begin
      rdata <= glyph_mem[raddr_full[MEM_AW-1:0]];
    end
  end

  // cursor
  logic [POS_W-1:0] col_pos;
  logic [POS_W-1:0] row_pos;
  logic [POS_W-1:0] col_next;
  logic [POS_W-1:0] row_next;
  logic [15:0]      x_tmp;
  logic [15:0]      y_tmp;

  always_comb begin
    x_tmp = {2'b00, col_pos};
    y_tmp = {2'b00, row_pos};
    case (cmd.cur_op)
      CUR_BACK: begin
        if (col_pos >= CELL_W) begin
          x_tmp = {2'b00, col_pos - CELL_W};
        end else if (row_pos >= LINE_H) begin
          y_tmp = {2'b00, row_pos - LINE_H};
          x_tmp = (screen_width[POS_W-1:3] != '0) ?
                  {2'b00, {screen_width[POS_W-1:3], 3'b000} - CELL_W} : 16'd0;
        end
      end
      CUR_NEWLINE: begin
        x_tmp = 16'd0;
        y_tmp = {2'b00, row_pos} + {2'b00, LINE_H};
      end
      CUR_ADVANCE: begin
        x_tmp = {2'b00, col_pos} + {2'b00, CELL_W};
        if (x_tmp + {2'b00, CELL_W} > {2'b00, screen_width}) begin
          x_tmp = 16'd0;
          y_tmp = {2'b00, row_pos} + {2'b00, LINE_H};
        end
      end
      default: ;
    endcase
    // wrap to the top after a newline, an advance or the end of a backspace, not after its pre-move
    if (cmd.cur_op == CUR_NEWLINE || cmd.cur_op == CUR_ADVANCE || cmd.cur_op == CUR_WRAP) begin
      if (y_tmp + {2'b00, LINE_H} > {2'b00, screen_height}) begin
        y_tmp = 16'd0;
      end
    end
    col_next = x_tmp[POS_W-1:0];
    row_next = y_tmp[POS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos <= '0;
      row_pos <= '0;
    end else begin
      col_pos <= col_next;
      row_pos <= row_next;
    end
  end

  // glyph scan
  logic [COLOR_W-1:0] color;
  logic [ADDR_W-1:0]  base;
  logic [POS_W:0]     row_y;
  logic [POS_W:0]     py;
  logic [POS_W:0]     px;
  logic [2*POS_W:0]   prod;
  logic [ADDR_W-1:0]  addr;
  logic               hit;
  logic               step;
  logic               out_free;
  logic               move_out;
  logic [ADDR_W-1:0]  pend_addr;
  logic               pend_valid;
  logic [ADDR_W-1:0]  out_addr;
  logic [COLOR_W-1:0] out_color;

  assign py       = {1'b0, row_pos} + {{(POS_W - ROW_W + 1){1'b0}}, row};
  assign prod     = py * line_pitch;
  assign px       = {1'b0, col_pos} + {{(POS_W - ROW_W + 1){1'b0}}, bitc};
  assign addr     = base + {{(ADDR_W - POS_W - 1){1'b0}}, px};
  assign hit      = rdata[bitc] && (px < {1'b0, screen_width}) &&
                    (row_y < {1'b0, screen_height});
  assign out_free = !m_tvalid || m_tready;

  assign sts.scan_stall  = hit && pend_valid && !out_free;
  assign sts.flush_stall = pend_valid && !out_free;
  assign sts.bit_last    = (bitc == ROW_W'(GLYPH_ROWS - 1));
  assign sts.row_last    = (row == ROW_W'(GLYPH_ROWS - 1));

  assign step     = cmd.scan && !sts.scan_stall;
  // the held pixel moves out when another one is found or at the flush, once the output register is free
  assign move_out = (step && hit && pend_valid) || (cmd.flush && pend_valid && out_free);

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      glyph <= in_glyph;
      color <= (in_glyph == CHAR_SPACE) ? BLANK_COLOR : TEXT_COLOR;
    end
    if (cmd.row_read) begin
      base  <= prod[ADDR_W-1:0];
      row_y <= py;
    end
    if (cmd.row_start) begin
      row  <= '0;
      bitc <= '0;
    end else if (step) begin
      bitc <= bitc + 1'b1;
      if (sts.bit_last) begin
        row <= row + 1'b1;
      end
    end
    if (step && hit) begin
      pend_addr <= addr;
    end
    if (move_out) begin
      out_addr  <= pend_addr;
      out_color <= color;
      m_tlast   <= cmd.flush;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (step && hit) begin
        pend_valid <= 1'b1;
      end else if (cmd.flush && out_free) begin
        pend_valid <= 1'b0;
      end
      if (move_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tdata = {6'b000000, out_color, out_addr};

endmodule

// File: hw/rtl/framebuffer_text_console.sv
// Top level of the framebuffer text console: register port and unit hookup.
//
// The input stream carries one request per beat: s_tuser selects printing a
// character (0) or loading one 8-pixel glyph row (1). The output stream carries
// one framebuffer pixel write per beat; m_tlast marks the last write of a
// character. Registers (width, height, pitch, framebuffer present) sit on the
// APB port at byte addresses 0, 4, 8 and 12.
// A glyph row load, a null and a newline are done in the cycle they are accepted;
// a character that draws nothing then updates the cursor in its own state. A
// drawn character goes through the accept, then for each of the 8 glyph rows a
// glyph store read that also forms the row base with the pitch multiplier and a
// scan over the glyph bits, then a flush and a cursor update. Pixel writes leave
// through an output register; each found pixel is held until the next is found
// or the flush, so that the last one can be marked. If the receiver stalls, the
// scan (at a found pixel) or flush waits for the output register; none is lost.
// Reset clears the cursor to the top left, loads the default geometry and
// clears framebuffer present; the glyph store is not cleared and must be
// loaded before characters are printed.
module framebuffer_text_console #(
  parameter int GLYPH_COUNT = fbtc_pkg::GLYPH_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // char_code[7:0], row_index[10:8], row_bits[18:11]
  input  logic        s_tuser,   // mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // pixel_address[25:0], pixel_color[57:26]
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import fbtc_pkg::*;

  logic [POS_W-1:0] screen_width;
  logic [POS_W-1:0] screen_height;
  logic [POS_W-1:0] line_pitch;
  logic             framebuffer_present;
  logic             reg_write;
  reg_idx_t         reg_idx;
  dp_cmd_t          cmd;
  dp_sts_t          sts;

  assign pready    = 1'b1;
  assign reg_write = psel && penable && pwrite && pready;
  assign reg_idx   = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width        <= WIDTH_RST;
      screen_height       <= HEIGHT_RST;
      line_pitch          <= PITCH_RST;
      framebuffer_present <= 1'b0;
    end else if (reg_write) begin
      case (reg_idx)
        REG_WIDTH:      screen_width        <= pwdata[POS_W-1:0];
        REG_HEIGHT:     screen_height       <= pwdata[POS_W-1:0];
        REG_PITCH:      line_pitch          <= pwdata[POS_W-1:0];
        REG_FB_PRESENT: framebuffer_present <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_WIDTH:      prdata = {18'd0, screen_width};
      REG_HEIGHT:     prdata = {18'd0, screen_height};
      REG_PITCH:      prdata = {18'd0, line_pitch};
      REG_FB_PRESENT: prdata = {31'd0, framebuffer_present};
      default:        prdata = 32'd0;
    endcase
  end

  fbtc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fbtc_dp #(
    .GLYPH_COUNT (GLYPH_COUNT)
  ) u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .sts                 (sts),
    .screen_width        (screen_width),
    .screen_height       (screen_height),
    .line_pitch          (line_pitch),
    .framebuffer_present (framebuffer_present),
    .s_tdata             (s_tdata),
    .s_tuser             (s_tuser),
    .m_tvalid            (m_tvalid),
    .m_tready            (m_tready),
    .m_tdata             (m_tdata),
    .m_tlast             (m_tlast)
  );

endmodule

// File: sim/framebuffer_text_console_tb.sv
// Self-checking testbench for the framebuffer text console: font loads, printing, cursor moves.
`timescale 1ns / 1ps

module framebuffer_text_console_tb;
  import fbtc_pkg::*;

  localparam logic MODE_PRINT = 1'b0;
  localparam logic MODE_LOAD  = 1'b1;

  localparam logic [CODE_W-1:0] GLYPH_SOLID  = 8'd127;
  localparam logic [CODE_W-1:0] GLYPH_EDGES  = 8'd1;
  localparam logic [CODE_W-1:0] GLYPH_LETTER = 8'd65;
  localparam logic [CODE_W-1:0] GLYPH_OUTER  = 8'd200;
  localparam logic [CODE_W-1:0] GLYPH_TOP    = 8'd255;

  localparam int DRAIN_CYCLES = 100;
  localparam int IDLE_LIMIT   = 4000;
  localparam int LONG_HOLD    = 400;

  typedef struct packed {
    logic              mode;
    logic [CODE_W-1:0] code;
    logic [ROW_W-1:0]  row;
    logic [7:0]        bits;
  } console_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [COLOR_W-1:0] color;
    logic               last;
  } pixel_write_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;  // char_code[7:0], row_index[10:8], row_bits[18:11]
  logic        s_tuser = 1'b0; // mode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;        // pixel_address[25:0], pixel_color[57:26]
  logic        m_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  framebuffer_text_console u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Console state as the block should hold it
  int unsigned cfg_width  = WIDTH_RST;
  int unsigned cfg_height = HEIGHT_RST;
  int unsigned cfg_pitch  = PITCH_RST;
  bit          cfg_fb_present = 1'b0;
  int unsigned cur_col = 0;
  int unsigned cur_row = 0;
  logic [7:0]  font_rows [GLYPH_COUNT_DEF*GLYPH_ROWS];

  pixel_write_t pending_pixels[$];
  console_req_t req_q[$];

  // Generation-side view of which glyphs are fully loaded
  logic [7:0]        rows_seen [GLYPH_COUNT_DEF];
  logic [CODE_W-1:0] ready_codes[$];

  int mismatches    = 0;
  int reqs_accepted = 0;
  int pixels_seen   = 0;
  int reg_writes    = 0;
  int phases_run    = 0;
  int idle_cycles   = 0;
  int hold_requests = 0;

  function automatic void note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH: %s", msg);
  endfunction

  function automatic void draw_glyph(input logic [CODE_W-1:0] code,
                                     input logic [COLOR_W-1:0] color);
    int unsigned px, py;
    int r, b, first;
    logic [7:0] bits;
    longint unsigned a;
    pixel_write_t pw;
    first = pending_pixels.size();
    if (!cfg_fb_present || code >= CODE_LIMIT || code >= GLYPH_COUNT_DEF) return;
    for (r = 0; r < GLYPH_ROWS; r++) begin
      bits = font_rows[int'(code) * GLYPH_ROWS + r];
      for (b = 0; b < 8; b++) begin
        py = cur_row + r;
        px = cur_col + b;
        if (bits[b] && px < cfg_width && py < cfg_height) begin
          a = longint'(py) * cfg_pitch + px;
          pw.addr  = a[ADDR_W-1:0];
          pw.color = color;
          pw.last  = 1'b0;
          pending_pixels.push_back(pw);
        end
      end
    end
    if (pending_pixels.size() > first)
      pending_pixels[pending_pixels.size()-1].last = 1'b1;
  endfunction

  // Apply one accepted request: update font/cursor, queue the pixel writes it causes
  function automatic void apply_request(input console_req_t r);
    int unsigned x, y;
    x = cur_col;
    y = cur_row;
    if (r.mode == MODE_LOAD) begin
      if (r.code < GLYPH_COUNT_DEF) font_rows[int'(r.code) * GLYPH_ROWS + r.row] = r.bits;
      return;
    end
    if (r.code == CHAR_NUL) return;
    if (r.code == CHAR_LF) begin
      x = 0;
      y += LINE_H;
    end else if (r.code == CHAR_BS) begin
      if (x >= CELL_W) begin
        x -= CELL_W;
      end else if (y >= LINE_H) begin
        y -= LINE_H;
        x = (cfg_width >= CELL_W) ? (cfg_width / CELL_W) * CELL_W - CELL_W : 0;
      end
      cur_col = x % (1 << POS_W);
      cur_row = y % (1 << POS_W);
      draw_glyph(CHAR_SPACE, BLANK_COLOR);
      x = cur_col;
      y = cur_row;
    end else begin
      draw_glyph(r.code, (r.code == CHAR_SPACE) ? BLANK_COLOR : TEXT_COLOR);
      x += CELL_W;
      if (x + CELL_W > cfg_width) begin
        x = 0;
        y += LINE_H;
      end
    end
    if (y + LINE_H > cfg_height) y = 0;
    cur_col = x % (1 << POS_W);
    cur_row = y % (1 << POS_W);
  endfunction

  function automatic void push_load(input logic [CODE_W-1:0] idx, input logic [ROW_W-1:0] row,
                                    input logic [7:0] bits);
    console_req_t r;
    r = '{mode: MODE_LOAD, code: idx, row: row, bits: bits};
    req_q.push_back(r);
    if (idx < GLYPH_COUNT_DEF && rows_seen[idx] != 8'hFF) begin
      rows_seen[idx][row] = 1'b1;
      if (rows_seen[idx] == 8'hFF && idx != CHAR_NUL && idx != CHAR_BS && idx != CHAR_LF)
        ready_codes.push_back(idx);
    end
  endfunction

  function automatic void push_print(input logic [CODE_W-1:0] code);
    console_req_t r;
    // row and bits are don't-care when printing; randomize them anyway
    r = '{mode: MODE_PRINT, code: code, row: ROW_W'($urandom), bits: 8'($urandom)};
    req_q.push_back(r);
  endfunction

  // Mostly well-formed traffic: full glyph loads followed by prints, plus control codes
  function automatic void add_random_requests(input int count, input int lf_pct);
    int made, sel, idx, k, r, t;
    made = 0;
    t = 14 + lf_pct;
    while (made < count) begin
      sel = $urandom_range(0, 99);
      if (sel < 8) begin
        idx = $urandom_range(1, GLYPH_COUNT_DEF - 1);
        for (r = 0; r < GLYPH_ROWS; r++) push_load(idx, r, $urandom_range(0, 255));
        k = $urandom_range(1, 3);
        repeat (k) push_print(idx);
        made += GLYPH_ROWS + k;
      end else begin
        if (sel < 14)
          push_load($urandom_range(0, 255), $urandom_range(0, 7), $urandom_range(0, 255));
        else if (sel < t) push_print(CHAR_LF);
        else if (sel < t + 8) push_print(CHAR_BS);
        else if (sel < t + 16) push_print($urandom_range(CODE_LIMIT, 255));
        else if (sel < t + 19) push_print(CHAR_NUL);
        else if (sel < t + 25) push_print(CHAR_SPACE);
        else push_print(ready_codes[$urandom_range(0, ready_codes.size() - 1)]);
        made++;
      end
    end
  endfunction

  // Sender: bursts of random length with random gaps
  console_req_t in_flight;
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        apply_request(in_flight);
        reqs_accepted++;
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0 || req_q.size() == 0) begin
          if (gap_left > 0) gap_left--;
          s_tvalid <= 1'b0;
        end else begin
          in_flight = req_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {5'b0, in_flight.bits, in_flight.row, in_flight.code};
          s_tuser  <= in_flight.mode;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  // Receiver: stall style is redrawn when its countdown runs out; long hold on request
  int holds_served = 0;
  int hold_left = 0;
  int rx_style = 0;
  int rx_style_left = 0;
  int rx_tick = 0;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      rx_tick++;
      if (holds_served != hold_requests) begin
        holds_served++;
        hold_left = LONG_HOLD;
      end
      if (rx_style_left == 0) begin
        rx_style      = $urandom_range(0, 3);
        rx_style_left = $urandom_range(64, 256);
      end else begin
        rx_style_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        case (rx_style)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= (rx_tick % 4 == 0);
          default: m_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Output checker
  always @(posedge clk) begin
    pixel_write_t want;
    if (!rst && m_tvalid && m_tready) begin
      pixels_seen++;
      if (pending_pixels.size() == 0) begin
        note_mismatch($sformatf("unexpected pixel write addr=%0h color=%0h last=%0b",
                                m_tdata[25:0], m_tdata[57:26], m_tlast));
      end else begin
        want = pending_pixels.pop_front();
        if (m_tdata[25:0] !== want.addr)
          note_mismatch($sformatf("pixel_address exp %0h got %0h", want.addr, m_tdata[25:0]));
        if (m_tdata[57:26] !== want.color)
          note_mismatch($sformatf("pixel_color exp %0h got %0h", want.color, m_tdata[57:26]));
        if (m_tlast !== want.last)
          note_mismatch($sformatf("last_pixel exp %0b got %0b (addr %0h)",
                                  want.last, m_tlast, want.addr));
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no handshake for %0d cycles, %0d writes still expected",
               IDLE_LIMIT, pending_pixels.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic reg_write(input reg_idx_t idx, input logic [31:0] value);
    logic [31:0] mask;
    mask = (idx == REG_FB_PRESENT) ? 32'h1 : 32'h3FFF;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      REG_WIDTH:  cfg_width  = value & mask;
      REG_HEIGHT: cfg_height = value & mask;
      REG_PITCH:  cfg_pitch  = value & mask;
      default:    cfg_fb_present = value[0];
    endcase
    reg_writes++;
    // read back the same register
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if ((prdata & mask) !== (value & mask))
      note_mismatch($sformatf("register %s read %0h, wrote %0h", idx.name(), prdata, value));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_geometry(input int w, input int h, input int p, input bit fb);
    reg_write(REG_WIDTH, w);
    reg_write(REG_HEIGHT, h);
    reg_write(REG_PITCH, p);
    reg_write(REG_FB_PRESENT, fb);
    phases_run++;
  endtask

  // Wait until every request is taken and every write has come out, then let the block settle
  task automatic wait_idle();
    while (req_q.size() != 0 || s_tvalid || pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int r, mark;
    for (r = 0; r < GLYPH_COUNT_DEF; r++) rows_seen[r] = 8'h00;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Default geometry, framebuffer on
    set_geometry(WIDTH_RST, HEIGHT_RST, PITCH_RST, 1'b1);
    for (r = 0; r < GLYPH_ROWS; r++) begin
      push_load(CHAR_SPACE, r, $urandom_range(1, 255));
      push_load(GLYPH_SOLID, r, 8'hFF);
      push_load(GLYPH_EDGES, r, r[0] ? 8'h80 : 8'h01);
      push_load(GLYPH_LETTER, r, $urandom_range(0, 255));
    end
    push_print(CHAR_NUL);
    push_print(CHAR_BS);           // at the origin: cursor stays, blank drawn
    push_print(GLYPH_SOLID);       // full 64-pixel glyph
    push_print(GLYPH_EDGES);
    push_print(GLYPH_LETTER);
    push_print(CHAR_SPACE);
    push_print(CHAR_BS);
    push_print(CHAR_LF);
    push_print(CHAR_BS);           // back onto the last cell of the previous line
    push_print(CODE_LIMIT);        // skipped, cursor wraps to next line
    push_print(GLYPH_TOP);
    push_load(GLYPH_OUTER, 3'd7, 8'hFF);
    push_load(GLYPH_TOP, 3'd0, 8'hAA);
    push_print(GLYPH_OUTER);
    push_load(CHAR_NUL, 3'd7, 8'h80);
    push_load(GLYPH_SOLID, 3'd0, 8'h00);
    push_print(GLYPH_SOLID);
    push_load(GLYPH_SOLID, 3'd0, 8'hFF);
    push_print(GLYPH_SOLID);
    wait_idle();

    // Narrow screen right after a wide one: clipping on the old cursor, wraps
    set_geometry(20, 25, 20, 1'b1);
    add_random_requests(100, 10);
    wait_idle();

    // Narrower than a cell: backspace target saturates, columns clip
    set_geometry(5, 7, 5, 1'b1);
    add_random_requests(60, 10);
    wait_idle();

    // Largest geometry, many newlines
    set_geometry(8192, 8192, 8192, 1'b1);
    add_random_requests(80, 40);
    wait_idle();

    // Zero-sized screen: nothing visible
    set_geometry(0, 0, 0, 1'b1);
    add_random_requests(30, 10);
    wait_idle();

    // No framebuffer: cursor moves, nothing drawn
    set_geometry(100, 100, 128, 1'b0);
    add_random_requests(40, 10);
    wait_idle();

    // Long receiver hold while the sender keeps offering
    set_geometry(200, 60, 256, 1'b1);
    mark = reqs_accepted;
    add_random_requests(150, 10);
    while (reqs_accepted < mark + 20) @(posedge clk);
    hold_requests <= hold_requests + 1;
    wait_idle();

    $display("Ran %0d requests over %0d geometry phases (%0d register writes),",
             reqs_accepted, phases_run, reg_writes);
    $display("checked %0d pixel writes, %0d mismatches", pixels_seen, mismatches);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
